/* rtl/slt_pkg.sv */
// Shared token kinds, run descriptor type and keyword text for the token lexer.
package slt_pkg;

  localparam logic [4:0] K_EOF    = 5'd0;
  localparam logic [4:0] K_EOL    = 5'd1;
  localparam logic [4:0] K_KW0    = 5'd2;
  localparam logic [4:0] K_LPAREN = 5'd12;
  localparam logic [4:0] K_RPAREN = 5'd13;
  localparam logic [4:0] K_COMMA  = 5'd14;
  localparam logic [4:0] K_ADD    = 5'd15;
  localparam logic [4:0] K_SUB    = 5'd16;
  localparam logic [4:0] K_MUL    = 5'd17;
  localparam logic [4:0] K_DIV    = 5'd18;
  localparam logic [4:0] K_MOD    = 5'd19;
  localparam logic [4:0] K_ASSIGN = 5'd20;
  localparam logic [4:0] K_LT     = 5'd22;
  localparam logic [4:0] K_GT     = 5'd24;
  localparam logic [4:0] K_NUM    = 5'd26;
  localparam logic [4:0] K_ICHAR  = 5'd27;
  localparam logic [4:0] K_IEND   = 5'd28;
  localparam logic [4:0] K_ERR    = 5'd29;

  localparam int PREFIX_DEPTH = 7;

  // One accepted word's results: held prefix characters, then up to two tokens.
  typedef struct packed {
    logic [2:0]                          nflush;
    logic [1:0]                          next;
    logic [PREFIX_DEPTH-1:0][7:0]        prefix;
    logic [4:0]                          kind0;
    logic [31:0]                         val0;
    logic [4:0]                          kind1;
    logic [7:0]                          val1;
  } desc_t;

  // Keyword text, first character in the top byte; zero past the end.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [63:0] s;
    logic [63:0] t;
    s = 64'h0;
    case (k)
      4'd0: s = {"and", 40'h0};
      4'd1: s = {"end", 40'h0};
      4'd2: s = {"else", 32'h0};
      4'd3: s = "function";
      4'd4: s = {"if", 48'h0};
      4'd5: s = {"not", 40'h0};
      4'd6: s = {"or", 48'h0};
      4'd7: s = {"return", 16'h0};
      4'd8: s = {"var", 40'h0};
      4'd9: s = {"while", 24'h0};
      default: s = 64'h0;
    endcase
    t = s << {p[2:0], 3'b000};
    return p[3] ? 8'h00 : t[63:56];
  endfunction

endpackage

/* rtl/slt_front.sv */
// Front end: classifies each source word and builds its result descriptor.
module slt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_byte,
  input  logic          end_of_source,
  output logic          push,
  output slt_pkg::desc_t desc
);
  import slt_pkg::*;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_KEYWORD = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_IDENT   = 4'd3;
  localparam logic [3:0] M_PEND_EQ = 4'd4;
  localparam logic [3:0] M_PEND_LT = 4'd5;
  localparam logic [3:0] M_PEND_GT = 4'd6;
  localparam logic [3:0] M_COMMENT = 4'd7;
  localparam logic [3:0] M_ERROR   = 4'd8;

  localparam logic [3:0] KW_END  = 4'd1;
  localparam logic [3:0] KW_ELSE = 4'd2;

  typedef struct packed {
    logic [3:0] mode;
    logic       emit;
    logic [4:0] kind;
    logic       start_kw;
    logic [3:0] kw;
    logic       start_num;
  } bt_t;

  logic [3:0]                   mode, mode_next;
  logic [3:0]                   cand, cand_next;
  logic [2:0]                   mp, mp_next;
  logic [PREFIX_DEPTH-1:0][7:0] pbuf, pbuf_next;
  logic [31:0]                  acc, acc_next;

  logic [1:0]  tn;
  logic [4:0]  tk [2];
  logic [31:0] tv [2];
  logic [2:0]  nflush;
  bt_t         bt;
  logic        fin;
  logic [7:0]  c, l;
  logic [3:0]  k;
  logic        c_digit, c_ident;

  function automatic logic [7:0] to_lower(input logic [7:0] x);
    return (x >= "A" && x <= "Z") ? x + 8'd32 : x;
  endfunction

  function automatic logic is_digit(input logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic logic is_ident(input logic [7:0] x);
    return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || is_digit(x) || x == "_";
  endfunction

  // Classify the first character of a new token.
  function automatic bt_t begin_token(input logic [7:0] x);
    bt_t r;
    r = '0;
    r.mode = M_IDLE;
    if (x == " " || x == 8'd13) begin
      r.mode = M_IDLE;
    end else if (x == "#") begin
      r.mode = M_COMMENT;
    end else if (x == 8'd10) begin
      r.emit = 1'b1;
      r.kind = K_EOL;
    end else begin
      r.start_kw = 1'b1;
      r.mode = M_KEYWORD;
      case (to_lower(x))
        "a": r.kw = 4'd0;
        "e": r.kw = 4'd1;
        "f": r.kw = 4'd3;
        "i": r.kw = 4'd4;
        "n": r.kw = 4'd5;
        "o": r.kw = 4'd6;
        "r": r.kw = 4'd7;
        "v": r.kw = 4'd8;
        "w": r.kw = 4'd9;
        default: begin
          r.start_kw = 1'b0;
          r.mode = M_IDLE;
        end
      endcase
      if (!r.start_kw) begin
        r.emit = 1'b1;
        case (x)
          "(": r.kind = K_LPAREN;
          ")": r.kind = K_RPAREN;
          ",": r.kind = K_COMMA;
          "+": r.kind = K_ADD;
          "-": r.kind = K_SUB;
          "*": r.kind = K_MUL;
          "/": r.kind = K_DIV;
          "%": r.kind = K_MOD;
          "=": begin r.emit = 1'b0; r.mode = M_PEND_EQ; end
          "<": begin r.emit = 1'b0; r.mode = M_PEND_LT; end
          ">": begin r.emit = 1'b0; r.mode = M_PEND_GT; end
          default: begin
            if (is_digit(x)) begin
              r.emit = 1'b0;
              r.start_num = 1'b1;
              r.mode = M_NUMBER;
            end else if (is_ident(x)) begin
              r.kind = K_ICHAR;
              r.mode = M_IDENT;
            end else begin
              r.kind = K_ERR;
              r.mode = M_ERROR;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  assign c       = char_byte;
  assign l       = to_lower(char_byte);
  assign fin     = end_of_source || char_byte == 8'd0;
  assign c_digit = is_digit(char_byte);
  assign c_ident = is_ident(char_byte);
  assign bt      = begin_token(char_byte);

  // Next state and the token list for this word.
  always_comb begin
    mode_next = mode;
    cand_next = cand;
    mp_next   = mp;
    pbuf_next = pbuf;
    acc_next  = acc;
    tn        = 2'd0;
    tk[0]     = K_EOF;
    tk[1]     = K_EOF;
    tv[0]     = 32'd0;
    tv[1]     = 32'd0;
    nflush    = 3'd0;
    k         = cand;
    if (fin) begin
      case (mode)
        M_KEYWORD: begin nflush = mp; tk[0] = K_IEND; tn = 2'd1; end
        M_NUMBER:  begin tk[0] = K_NUM; tv[0] = acc; tn = 2'd1; end
        M_IDENT:   begin tk[0] = K_IEND; tn = 2'd1; end
        M_PEND_EQ: begin tk[0] = K_ASSIGN; tn = 2'd1; end
        M_PEND_LT: begin tk[0] = K_LT; tn = 2'd1; end
        M_PEND_GT: begin tk[0] = K_GT; tn = 2'd1; end
        M_COMMENT: begin tk[0] = K_EOL; tn = 2'd1; end
        default: tn = 2'd0;
      endcase
      if (mode != M_ERROR) begin
        tk[tn[0]] = K_EOF;
        tv[tn[0]] = 32'd0;
        tn = tn + 2'd1;
      end
      mode_next = M_IDLE;
      cand_next = 4'd0;
      mp_next   = 3'd0;
      acc_next  = 32'd0;
    end else begin
      case (mode)
        M_KEYWORD: begin
          if (cand == KW_END && mp == 3'd1 && l == "l") begin
            k = KW_ELSE;
          end
          cand_next = k;
          if (l == kw_char(k, {1'b0, mp}) && l != 8'd0) begin
            if (kw_char(k, {1'b0, mp} + 4'd1) == 8'd0 || mp == 3'd7) begin
              tk[0] = K_KW0 + {1'b0, k};
              tn = 2'd1;
              mode_next = M_IDLE;
              mp_next = 3'd0;
            end else begin
              pbuf_next[mp] = c;
              mp_next = mp + 3'd1;
            end
          end else begin
            nflush = mp;
            mp_next = 3'd0;
            tn = 2'd1;
            if (c_ident) begin
              tk[0] = K_ICHAR;
              tv[0] = {24'd0, c};
              mode_next = M_IDENT;
            end else begin
              tk[0] = K_IEND;
              mode_next = bt.mode;
            end
          end
        end
        M_NUMBER: begin
          if (c_digit) begin
            acc_next = (acc << 3) + (acc << 1) + {28'd0, c[3:0]};
          end else begin
            tk[0] = K_NUM;
            tv[0] = acc;
            tn = 2'd1;
            mode_next = bt.mode;
          end
        end
        M_IDENT: begin
          tn = 2'd1;
          if (c_ident) begin
            tk[0] = K_ICHAR;
            tv[0] = {24'd0, c};
          end else begin
            tk[0] = K_IEND;
            mode_next = bt.mode;
          end
        end
        M_PEND_EQ, M_PEND_LT, M_PEND_GT: begin
          tn = 2'd1;
          tk[0] = (mode == M_PEND_EQ) ? K_ASSIGN : (mode == M_PEND_LT) ? K_LT : K_GT;
          if (c == "=") begin
            tk[0] = tk[0] + 5'd1;
            mode_next = M_IDLE;
          end else begin
            mode_next = bt.mode;
          end
        end
        M_COMMENT: begin
          if (c == 8'd10) begin
            tk[0] = K_EOL;
            tn = 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_ERROR: mode_next = M_ERROR;
        default: mode_next = bt.mode;
      endcase
      // Apply the new-token classification where this word starts one.
      if (mode_next == bt.mode && mode != M_ERROR &&
          (mode == M_IDLE || (mode == M_KEYWORD && tk[0] == K_IEND && tn == 2'd1) ||
           (mode == M_NUMBER && !c_digit) || (mode == M_IDENT && !c_ident) ||
           ((mode == M_PEND_EQ || mode == M_PEND_LT || mode == M_PEND_GT) && c != "="))) begin
        if (bt.emit) begin
          tk[tn[0]] = bt.kind;
          tv[tn[0]] = (bt.kind == K_ICHAR) ? {24'd0, c} : 32'd0;
          tn = tn + 2'd1;
        end
        if (bt.start_kw) begin
          cand_next = bt.kw;
          pbuf_next[0] = c;
          mp_next = 3'd1;
        end
        if (bt.start_num) begin
          acc_next = {28'd0, c[3:0]};
        end
      end
    end
  end

  // Pack the descriptor for the queue.
  always_comb begin
    desc.nflush = nflush;
    desc.next   = tn;
    desc.prefix = pbuf;
    desc.kind0  = tk[0];
    desc.val0   = tv[0];
    desc.kind1  = tk[1];
    desc.val1   = tv[1][7:0];
  end

  assign push = accept && (nflush != 3'd0 || tn != 2'd0);

  // Advance lexer state on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      cand <= 4'd0;
      mp   <= 3'd0;
      acc  <= 32'd0;
    end else if (accept) begin
      mode <= mode_next;
      cand <= cand_next;
      mp   <= mp_next;
      acc  <= acc_next;
    end
  end

  // Hold prefix characters while matching.
  always_ff @(posedge clk) begin
    if (accept) begin
      pbuf <= pbuf_next;
    end
  end

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> mode == M_IDLE && mp == 3'd0)
    else $error("lexer not idle after end of source");

  a_mp_keyword: assert property (@(posedge clk) disable iff (rst)
    mode != M_KEYWORD |-> mp == 3'd0)
    else $error("match position set outside keyword matching");

  a_cand_range: assert property (@(posedge clk) disable iff (rst)
    mode == M_KEYWORD |-> cand <= 4'd9 && mp != 3'd0)
    else $error("bad keyword candidate");

endmodule

/* rtl/slt_queue.sv */
// Descriptor queue between the front end and the token sequencer.
module slt_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slt_pkg::desc_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output slt_pkg::desc_t head
);
  import slt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rp];

  // Store pushed descriptors.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/slt_back.sv */
// Back end: expands each descriptor into tokens, one token per cycle while tok_stall is low.
module slt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  slt_pkg::desc_t      head,
  output logic                pop,
  output logic                tok_valid,
  input  logic                tok_stall,
  output logic [4:0]          token_kind,
  output logic signed [31:0]  token_value,
  output logic                last_of_run
);
  import slt_pkg::*;

  logic [3:0]  idx;
  logic [3:0]  total;
  logic [3:0]  rel;
  logic        load;
  logic        fire;
  logic [4:0]  sel_kind;
  logic [31:0] sel_val;
  logic        sel_last;

  assign total = {1'b0, head.nflush} + {2'b00, head.next};
  assign rel   = idx - {1'b0, head.nflush};
  assign load  = !tok_valid || !tok_stall;
  assign fire  = load && head_valid;
  assign pop   = fire && sel_last;

  // Select the token at the current position of the run.
  always_comb begin
    sel_last = idx == total - 4'd1;
    if (idx < {1'b0, head.nflush}) begin
      sel_kind = K_ICHAR;
      sel_val  = {24'd0, head.prefix[idx[2:0]]};
    end else if (rel == 4'd0) begin
      sel_kind = head.kind0;
      sel_val  = head.val0;
    end else begin
      sel_kind = head.kind1;
      sel_val  = {24'd0, head.val1};
    end
  end

  // Step through the run.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 4'd0;
    end else if (fire) begin
      idx <= sel_last ? 4'd0 : idx + 4'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (load) begin
      tok_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      token_kind  <= sel_kind;
      token_value <= sel_val;
      last_of_run <= sel_last;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < total)
    else $error("run position past end of descriptor");

  a_idx_reset: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == 4'd0)
    else $error("run position not cleared after last token");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> tok_valid && last_of_run)
    else $error("descriptor retired without last token");

endmodule

/* rtl/script_token_lexer.sv */
// Top level of the script token lexer.
// Takes one source byte per cycle on src_valid/src_stall while src_stall is
// low and sends tokens on tok_valid/tok_stall. A word that flushes held
// keyword prefix characters produces up to nine tokens, which the token
// sequencer sends one per cycle while tok_stall is low, so the input stalls
// only when the descriptor queue (QUEUE_DEPTH runs) fills up.
module script_token_lexer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  logic [7:0]         char_byte,
  input  logic               end_of_source,
  output logic               tok_valid,
  input  logic               tok_stall,
  output logic [4:0]         token_kind,
  output logic signed [31:0] token_value,
  output logic               last_of_run
);
  import slt_pkg::*;

  logic  accept;
  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;
  desc_t desc;
  desc_t head;

  assign src_stall = full;
  assign accept    = src_valid && !full;

  slt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .char_byte     (char_byte),
    .end_of_source (end_of_source),
    .push          (push),
    .desc          (desc)
  );

  slt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (desc),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  slt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .tok_valid   (tok_valid),
    .tok_stall   (tok_stall),
    .token_kind  (token_kind),
    .token_value (token_value),
    .last_of_run (last_of_run)
  );

endmodule

/* bench/script_token_lexer_tb.sv */
// Self-checking testbench for the script token lexer: directed and random source streams.
module script_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slt_pkg::*;

  typedef enum logic [3:0] {
    LX_IDLE, LX_KEYWORD, LX_NUMBER, LX_IDENT, LX_PEND_EQ, LX_PEND_LT, LX_PEND_GT,
    LX_COMMENT, LX_ERROR
  } lex_mode_e;

  typedef struct {
    logic [4:0]  kind;
    logic [31:0] value;
    logic        last;
  } token_t;

  localparam int LIMIT_CYCLES = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               src_valid = 1'b0;
  logic               src_stall;
  logic [7:0]         char_byte = 8'd0;
  logic               end_of_source = 1'b0;
  logic               tok_valid;
  logic               tok_stall = 1'b0;
  logic [4:0]         token_kind;
  logic signed [31:0] token_value;
  logic               last_of_run;

  // Lexer shadow state
  lex_mode_e   lx_mode = LX_IDLE;
  int          kw_cand = 0;
  int          kw_pos = 0;
  logic [7:0]  held_chars [8];
  logic [31:0] num_acc = 0;
  token_t      word_tokens [$];
  token_t      expected_tokens [$];

  string kw_words [10] = '{"and", "end", "else", "function", "if", "not", "or", "return",
                           "var", "while"};

  int  errors = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  int  gap_max = 0;
  int  stall_style = 0;

  script_token_lexer DUT (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall),
    .char_byte(char_byte), .end_of_source(end_of_source),
    .tok_valid(tok_valid), .tok_stall(tok_stall),
    .token_kind(token_kind), .token_value(token_value), .last_of_run(last_of_run)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) || c == "_";
  endfunction

  function automatic logic [7:0] kw_letter(int k, int p);
    return (p < kw_words[k].len()) ? kw_words[k][p] : 8'd0;
  endfunction

  function automatic void add_token(logic [4:0] kind, logic [31:0] value);
    token_t t;
    t.kind = kind;
    t.value = value;
    t.last = 1'b0;
    if (word_tokens.size() < 9) word_tokens.push_back(t);
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < kw_pos; i++) add_token(K_ICHAR, {24'd0, held_chars[i]});
  endfunction

  // Start a new token from an idle lexer
  function automatic void start_token(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    lx_mode = LX_IDLE;
    if (c == " " || c == 8'd13) return;
    if (c == "#") begin
      lx_mode = LX_COMMENT;
      return;
    end
    if (c == 8'd10) begin
      add_token(K_EOL, 0);
      return;
    end
    for (int k = 0; k < 10; k++) begin
      if (kw_letter(k, 0) == l) begin
        kw_cand = k;
        held_chars[0] = c;
        kw_pos = 1;
        lx_mode = LX_KEYWORD;
        return;
      end
    end
    case (c)
      "(": add_token(K_LPAREN, 0);
      ")": add_token(K_RPAREN, 0);
      ",": add_token(K_COMMA, 0);
      "+": add_token(K_ADD, 0);
      "-": add_token(K_SUB, 0);
      "*": add_token(K_MUL, 0);
      "/": add_token(K_DIV, 0);
      "%": add_token(K_MOD, 0);
      "=": lx_mode = LX_PEND_EQ;
      "<": lx_mode = LX_PEND_LT;
      ">": lx_mode = LX_PEND_GT;
      default: begin
        if (is_digit(c)) begin
          num_acc = 32'(c - "0");
          lx_mode = LX_NUMBER;
        end else if (is_word_char(c)) begin
          add_token(K_ICHAR, {24'd0, c});
          lx_mode = LX_IDENT;
        end else begin
          add_token(K_ERR, 0);
          lx_mode = LX_ERROR;
        end
      end
    endcase
  endfunction

  // Advance a keyword match; "e" then "l" switches from end to else
  function automatic void match_keyword(logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    if (kw_cand == 1 && kw_pos == 1 && l == "l") kw_cand = 2;
    if (l != 0 && l == kw_letter(kw_cand, kw_pos)) begin
      if (kw_letter(kw_cand, kw_pos + 1) == 0 || kw_pos == 7) begin
        add_token(5'(K_KW0 + kw_cand), 0);
        lx_mode = LX_IDLE;
        kw_pos = 0;
      end else begin
        held_chars[kw_pos] = c;
        kw_pos++;
      end
      return;
    end
    flush_held();
    kw_pos = 0;
    if (is_word_char(c)) begin
      add_token(K_ICHAR, {24'd0, c});
      lx_mode = LX_IDENT;
    end else begin
      add_token(K_IEND, 0);
      start_token(c);
    end
  endfunction

  function automatic void close_source();
    bit send_eof;
    send_eof = 1'b1;
    case (lx_mode)
      LX_KEYWORD: begin
        flush_held();
        add_token(K_IEND, 0);
      end
      LX_NUMBER:  add_token(K_NUM, num_acc);
      LX_IDENT:   add_token(K_IEND, 0);
      LX_PEND_EQ: add_token(K_ASSIGN, 0);
      LX_PEND_LT: add_token(K_LT, 0);
      LX_PEND_GT: add_token(K_GT, 0);
      LX_COMMENT: add_token(K_EOL, 0);
      LX_ERROR:   send_eof = 1'b0;
      default: ;
    endcase
    if (send_eof) add_token(K_EOF, 0);
    lx_mode = LX_IDLE;
    kw_cand = 0;
    kw_pos = 0;
    num_acc = 0;
  endfunction

  // Work out the tokens one accepted word causes and queue them
  function automatic void lex_word(logic [7:0] c, logic eos);
    logic [4:0] base;
    word_tokens.delete();
    if (eos || c == 0) close_source();
    else begin
      case (lx_mode)
        LX_KEYWORD: match_keyword(c);
        LX_NUMBER: begin
          if (is_digit(c)) num_acc = num_acc * 10 + 32'(c - "0");
          else begin
            add_token(K_NUM, num_acc);
            start_token(c);
          end
        end
        LX_IDENT: begin
          if (is_word_char(c)) add_token(K_ICHAR, {24'd0, c});
          else begin
            add_token(K_IEND, 0);
            start_token(c);
          end
        end
        LX_PEND_EQ, LX_PEND_LT, LX_PEND_GT: begin
          base = (lx_mode == LX_PEND_EQ) ? K_ASSIGN : (lx_mode == LX_PEND_LT) ? K_LT : K_GT;
          if (c == "=") begin
            add_token(base + 5'd1, 0);
            lx_mode = LX_IDLE;
          end else begin
            add_token(base, 0);
            start_token(c);
          end
        end
        LX_COMMENT: begin
          if (c == 8'd10) begin
            add_token(K_EOL, 0);
            lx_mode = LX_IDLE;
          end
        end
        LX_ERROR: ;
        default: start_token(c);
      endcase
    end
    if (word_tokens.size() > 0) word_tokens[word_tokens.size() - 1].last = 1'b1;
    foreach (word_tokens[i]) expected_tokens.push_back(word_tokens[i]);
  endfunction

  // Send one word, with random bursts and gaps ahead of it
  task automatic send_word(logic [7:0] c, logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        src_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    src_valid <= 1'b1;
    char_byte <= eos ? 8'($urandom) : c;
    end_of_source <= eos;
    do @(posedge clk); while (src_stall);
    lex_word(c, eos);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic wait_idle();
    src_valid <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Hold off the token side on a pattern of its own
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (stall_style)
      1: tok_stall <= ($urandom_range(0, 99) < 35);
      2: tok_stall <= (cycle_count % 7) < 4;
      default: tok_stall <= 1'b0;
    endcase
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Compare each accepted token with the oldest expected one
  always @(posedge clk) begin
    token_t e;
    if (!rst && tok_valid && !tok_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token kind %0d value %0d", token_kind, token_value);
        errors++;
      end else begin
        e = expected_tokens.pop_front();
        if (token_kind !== e.kind) begin
          $error("token_kind expected %0d actual %0d", e.kind, token_kind);
          errors++;
        end
        if (token_value !== e.value) begin
          $error("token_value expected %0d actual %0d", e.value, token_value);
          errors++;
        end
        if (last_of_run !== e.last) begin
          $error("last_of_run expected %0d actual %0d", e.last, last_of_run);
          errors++;
        end
      end
    end
  end

  // Keywords in mixed case, overlap, prefix flush and paired operators
  task automatic test_keywords();
    gap_max = 0;
    stall_style = 0;
    send_text("AnDy eLse functioX(>=<=");
    send_word(8'd0, 1'b1);
  endtask

  // Numbers that wrap, comments, error path and the zero terminator
  task automatic test_specials();
    stall_style = 2;
    send_text("99999999999=\r#z\n<>\t==");
    send_word(8'd0, 1'b1);
    send_text("#open");
    send_word(8'd0, 1'b0);
    send_text("x,+-*/%");
    send_word(8'hFF, 1'b0);
    send_text("ab");
    send_word(8'd0, 1'b1);
  endtask

  function automatic string random_fragment();
    string s;
    string ops;
    int k;
    int n;
    s = "";
    ops = "(),+-*/%";
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        k = $urandom_range(0, 9);
        n = $urandom_range(1, kw_words[k].len());
        for (int i = 0; i < n; i++)
          s = {s, string'($urandom_range(0, 1) ? kw_words[k][i] - 8'd32 : kw_words[k][i])};
      end
      3: for (int i = $urandom_range(1, 5); i > 0; i--)
           s = {s, string'(8'($urandom_range("a", "z")))};
      4: for (int i = $urandom_range(1, 12); i > 0; i--)
           s = {s, string'(8'($urandom_range("0", "9")))};
      5: begin
        k = $urandom_range(0, 10);
        if (k < 8) s = string'(ops[k]);
        else if (k == 8) s = "=";
        else if (k == 9) s = "<";
        else s = ">";
        if ($urandom_range(0, 1)) s = {s, "="};
      end
      6: s = " ";
      7: s = "\n";
      8: s = "#c x\n";
      9: s = "_Z9";
      10: s = "\r";
      default: s = string'(8'($urandom_range(1, 3) == 1 ? $urandom_range(128, 255) : "a"));
    endcase
    return s;
  endfunction

  // Well-formed token streams with occasional noise, many sources
  task automatic test_random_sources();
    int sent;
    string s;
    sent = 0;
    while (sent < 85) begin
      stall_style = $urandom_range(0, 2);
      gap_max = $urandom_range(0, 1) ? 0 : 5;
      for (int f = $urandom_range(3, 8); f > 0; f--) begin
        s = random_fragment();
        send_text(s);
        sent += s.len();
        if ($urandom_range(0, 20) == 0) begin
          send_word(8'($urandom_range(1, 255)), 1'b0);
          sent++;
        end
      end
      send_word(8'd0, 1'($urandom_range(0, 1)));
      sent++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_keywords();
    test_specials();
    test_random_sources();
    wait_idle();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
